// ===== rtl/ccc_pkg.sv =====
// ----------------------------------------------------------------------------
// ccc_pkg - circle contact shared definitions
// Widths, pipeline depths, sideband types and the arithmetic step functions
// used by the circle contact pipeline and its root and divide units.
// ----------------------------------------------------------------------------
package ccc_pkg;

    // square root unit: 32 steps in total, spread over registered stages
    localparam int unsigned SQ_STEPS   = 4;
    localparam int unsigned SQ_STAGES  = 8;
    // divider: 31 quotient bits, spread over registered stages
    localparam int unsigned DIV_STEPS  = 4;
    localparam int unsigned DIV_STAGES = 8;
    localparam int unsigned QUO_BITS   = 31;

    // pipeline depth around the two units
    localparam int unsigned FRONT_STAGES = 6;
    localparam int unsigned BACK_STAGES  = 6;
    localparam int unsigned LATENCY = FRONT_STAGES + SQ_STAGES + 1 + DIV_STAGES
                                    + BACK_STAGES + SQ_STAGES + 1;

    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [61:0] HALF_Q30 = 62'h2000_0000;

    // circle pair carried down the pipe
    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic [30:0]        ra;
        logic [30:0]        rb;
    } t_circ;

    // sideband alongside the first root
    typedef struct packed {
        t_circ       c;
        logic [30:0] sx;
        logic [30:0] sy;
        logic        coll;
        logic        neg_x;
        logic        neg_y;
        logic        zero;
    } t_sb1;

    // sideband alongside the dividers
    typedef struct packed {
        t_circ c;
        logic  coll;
        logic  neg_x;
        logic  neg_y;
        logic  zero;
    } t_sb2;

    // sideband alongside the depth root
    typedef struct packed {
        logic               coll;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic               over;
    } t_sb3;

    // root state: remainder and partial root
    typedef struct packed {
        logic [63:0] v;
        logic [63:0] res;
    } t_sq;

    // divider state
    typedef struct packed {
        logic [61:0] rem;
        logic [31:0] den;
        logic [30:0] quo;
    } t_dv;

    // one step of the digit-by-digit square root
    function automatic t_sq sq_step(t_sq s, int unsigned i);
        logic [63:0] bit_v;
        logic [63:0] t;
        t_sq         r;
        bit_v = 64'd1 << (62 - 2 * i);
        t     = s.res + bit_v;
        r     = s;
        if (s.v >= t) begin
            r.v   = s.v - t;
            r.res = (s.res >> 1) + bit_v;
        end else begin
            r.res = s.res >> 1;
        end
        return r;
    endfunction

    function automatic t_sq sq_stage(t_sq s, int unsigned stg);
        t_sq r;
        r = s;
        for (int unsigned k = 0; k < SQ_STEPS; k++) begin
            r = sq_step(r, stg * SQ_STEPS + k);
        end
        return r;
    endfunction

    // one restoring divide step; steps past the last quotient bit pass through
    function automatic t_dv dv_step(t_dv s, int unsigned j);
        logic [62:0] sh;
        t_dv         r;
        int unsigned b;
        r = s;
        if (j < QUO_BITS) begin
            b  = QUO_BITS - 1 - j;
            sh = 63'(s.den) << b;
            if ({1'b0, s.rem} >= sh) begin
                r.rem    = s.rem - sh[61:0];
                r.quo[b] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic t_dv dv_stage(t_dv s, int unsigned stg);
        t_dv r;
        r = s;
        for (int unsigned k = 0; k < DIV_STEPS; k++) begin
            r = dv_step(r, stg * DIV_STEPS + k);
        end
        return r;
    endfunction

    // leading zero count of a 32-bit word, 32 for zero
    function automatic logic [5:0] lzc32(logic [31:0] v);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) n = 6'(31 - i);
        end
        return n;
    endfunction

    function automatic logic [31:0] abs33(logic signed [32:0] d);
        logic [32:0] m;
        m = d[32] ? 33'(-d) : 33'(d);
        return m[31:0];
    endfunction

    // centre plus or minus the rounded normal*radius term, saturated
    function automatic logic signed [31:0] rim_pt(logic signed [31:0] c,
                                                  logic [61:0] p,
                                                  logic neg, logic sub);
        logic [61:0]        rnd;
        logic signed [33:0] t;
        logic signed [33:0] s;
        logic signed [31:0] r;
        rnd = p + HALF_Q30;
        t   = $signed({2'b00, rnd[61:30]});
        if (neg) t = -t;
        s = sub ? (34'(c) - t) : (34'(c) + t);
        if (s[33] == s[32] && s[32] == s[31]) r = s[31:0];
        else r = s[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return r;
    endfunction

endpackage

// ===== rtl/ccc_if.sv =====
// ----------------------------------------------------------------------------
// ccc_in_if / ccc_out_if - circle contact request and result channels
// Valid/ready channels carrying one circle pair and one contact result.
// ----------------------------------------------------------------------------
interface ccc_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic [30:0]        a_radius;
    logic [30:0]        b_radius;

    modport source (output valid, a_x, a_y, b_x, b_y, a_radius, b_radius,
                    input ready);
    modport sink   (input valid, a_x, a_y, b_x, b_y, a_radius, b_radius,
                    output ready);
endinterface

interface ccc_out_if;
    logic               valid;
    logic               ready;
    logic               colliding;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic [31:0]        depth;

    modport source (output valid, colliding, normal_x, normal_y, start_x,
                    start_y, end_x, end_y, depth, input ready);
    modport sink   (input valid, colliding, normal_x, normal_y, start_x,
                    start_y, end_x, end_y, depth, output ready);
endinterface

// ===== rtl/circle_circle_contact_core.sv =====
// ----------------------------------------------------------------------------
// circle_circle_contact_core - circle pair contact test
// Overlap flag, unit normal, rim points and depth for two circles.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one circle pair per request (centres and radii, Q16.16);
//   o_rsp returns one contact result per request, in request order.
//   Both channels are valid/ready; a request moves when both are high.
// Pipeline: six front stages (difference, squares, normalise), an 8-stage
//   root for the normal length, one numerator stage, 8-stage dividers for
//   the normal, six rim and distance stages, an 8-stage root for the depth
//   and the output register.
// Throughput: one request per cycle while the pipe is not held; no state is kept between pairs.
// Stall: the whole pipe holds while a result sits in the output register
//   and o_rsp.ready is low; i_req.ready drops in the same cycle. Nothing is
//   lost or repeated, and gaps in the pipe stay in place as it moves.
// Reset: synchronous, active low; clears the valid bits only, so the pipe
//   is empty and ready for a request straight after reset.
// ----------------------------------------------------------------------------
module circle_circle_contact_core import ccc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ccc_in_if.sink    i_req,
    ccc_out_if.source o_rsp
);

    localparam logic [31:0] NRM_MIN = 32'd759000000;

    logic adv;
    logic [LATENCY-1:0] r_vld;

    // pipe moves unless the output register holds an untaken result
    assign adv         = !r_vld[LATENCY-1] || o_rsp.ready;
    assign i_req.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LATENCY-2:0], i_req.valid};
        end
    end

    // ---------------- front stages ----------------
    logic signed [32:0] r_s1_dx, r_s1_dy;
    logic [31:0]        r_s1_rs;
    t_circ              r_s1_c;

    logic [31:0] r_s2_mx, r_s2_my, r_s2_rs;
    logic        r_s2_nx, r_s2_ny;
    t_circ       r_s2_c;

    logic [63:0] r_s3_mx2, r_s3_my2, r_s3_rs2;
    logic [31:0] r_s3_mx, r_s3_my;
    logic        r_s3_rsh, r_s3_nx, r_s3_ny, r_s3_zero;
    logic [4:0]  r_s3_lsh;
    t_circ       r_s3_c;

    logic [30:0] r_s4_sx, r_s4_sy;
    logic        r_s4_coll, r_s4_nx, r_s4_ny, r_s4_zero;
    t_circ       r_s4_c;

    logic [61:0] r_s5_sx2, r_s5_sy2;
    t_sb1        r_s5_sb;

    logic [62:0] r_s6_sum;
    t_sb1        r_s6_sb;

    logic [31:0] s3_max;
    logic [5:0]  s3_lz;
    logic [31:0] s4_shx, s4_shy;

    assign s3_max = (r_s2_mx > r_s2_my) ? r_s2_mx : r_s2_my;
    assign s3_lz  = lzc32(s3_max);
    assign s4_shx = r_s3_mx << r_s3_lsh;
    assign s4_shy = r_s3_my << r_s3_lsh;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // centre difference and radius sum
            r_s1_dx <= 33'(i_req.b_x) - 33'(i_req.a_x);
            r_s1_dy <= 33'(i_req.b_y) - 33'(i_req.a_y);
            r_s1_rs <= 32'(i_req.a_radius) + 32'(i_req.b_radius);
            r_s1_c  <= '{ax: i_req.a_x, ay: i_req.a_y, bx: i_req.b_x, by: i_req.b_y,
                         ra: i_req.a_radius, rb: i_req.b_radius};
            // magnitudes
            r_s2_mx <= abs33(r_s1_dx);
            r_s2_my <= abs33(r_s1_dy);
            r_s2_nx <= r_s1_dx[32];
            r_s2_ny <= r_s1_dy[32];
            r_s2_rs <= r_s1_rs;
            r_s2_c  <= r_s1_c;
            // squares for the overlap test, shift for normalising
            r_s3_mx2  <= 64'(r_s2_mx) * 64'(r_s2_mx);
            r_s3_my2  <= 64'(r_s2_my) * 64'(r_s2_my);
            r_s3_rs2  <= 64'(r_s2_rs) * 64'(r_s2_rs);
            r_s3_mx   <= r_s2_mx;
            r_s3_my   <= r_s2_my;
            r_s3_rsh  <= s3_max[31];
            r_s3_lsh  <= 5'(s3_lz - 6'd1);
            r_s3_zero <= (s3_max == 32'd0);
            r_s3_nx   <= r_s2_nx;
            r_s3_ny   <= r_s2_ny;
            r_s3_c    <= r_s2_c;
            // exact overlap compare; the larger scaled magnitude is in [2^30, 2^31) unless both are zero
            r_s4_coll <= ({1'b0, r_s3_mx2} + {1'b0, r_s3_my2}) <= {1'b0, r_s3_rs2};
            r_s4_sx   <= r_s3_rsh ? r_s3_mx[31:1] : s4_shx[30:0];
            r_s4_sy   <= r_s3_rsh ? r_s3_my[31:1] : s4_shy[30:0];
            r_s4_nx   <= r_s3_nx;
            r_s4_ny   <= r_s3_ny;
            r_s4_zero <= r_s3_zero;
            r_s4_c    <= r_s3_c;
            // squares of the scaled magnitudes
            r_s5_sx2 <= 62'(r_s4_sx) * 62'(r_s4_sx);
            r_s5_sy2 <= 62'(r_s4_sy) * 62'(r_s4_sy);
            r_s5_sb  <= '{c: r_s4_c, sx: r_s4_sx, sy: r_s4_sy, coll: r_s4_coll,
                          neg_x: r_s4_nx, neg_y: r_s4_ny, zero: r_s4_zero};
            // length squared
            r_s6_sum <= 63'(r_s5_sx2) + 63'(r_s5_sy2);
            r_s6_sb  <= r_s5_sb;
        end
    end

    // ---------------- normal length ----------------
    logic [31:0] len;
    t_sb1        r_d1 [SQ_STAGES];

    ccc_isqrt u_len (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_rad  ({1'b0, r_s6_sum}),
        .o_root (len)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d1[0] <= r_s6_sb;
            for (int k = 1; k < SQ_STAGES; k++) r_d1[k] <= r_d1[k-1];
        end
    end

    // rounded numerators for the normal components
    logic [61:0] r_s7_numx, r_s7_numy;
    logic [31:0] r_s7_den;
    t_sb2        r_s7_sb;
    t_sb1        d1_out;

    assign d1_out = r_d1[SQ_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s7_numx <= 62'({d1_out.sx, 30'd0}) + 62'(len >> 1);
            r_s7_numy <= 62'({d1_out.sy, 30'd0}) + 62'(len >> 1);
            r_s7_den  <= len;
            r_s7_sb   <= '{c: d1_out.c, coll: d1_out.coll, neg_x: d1_out.neg_x,
                           neg_y: d1_out.neg_y, zero: d1_out.zero};
        end
    end

    // ---------------- normal divide, one lane per axis ----------------
    logic [30:0] quo_x, quo_y;
    t_sb2        r_d2 [DIV_STAGES];

    ccc_div u_div_x (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_s7_numx),
        .i_den (r_s7_den),
        .o_quo (quo_x)
    );

    ccc_div u_div_y (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_s7_numy),
        .i_den (r_s7_den),
        .o_quo (quo_y)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d2[0] <= r_s7_sb;
            for (int k = 1; k < DIV_STAGES; k++) r_d2[k] <= r_d2[k-1];
        end
    end

    // ---------------- back stages ----------------
    t_sb2        d2_out;
    logic [30:0] s8_qx, s8_qy;

    logic [30:0]        r_s8_qx, r_s8_qy;
    logic signed [31:0] r_s8_nx, r_s8_ny;
    t_sb2               r_s8_sb;

    logic [61:0]        r_s9_pxb, r_s9_pyb, r_s9_pxa, r_s9_pya;
    logic signed [31:0] r_s9_nx, r_s9_ny;
    t_sb2               r_s9_sb;

    logic signed [31:0] r_s10_sx, r_s10_sy, r_s10_ex, r_s10_ey;
    logic signed [31:0] r_s10_nx, r_s10_ny;
    logic               r_s10_coll;

    logic [31:0] r_s11_mx, r_s11_my;
    t_sb3        r_s11_sb;

    logic [63:0] r_s12_mx2, r_s12_my2;
    t_sb3        r_s12_sb;

    logic [63:0] r_s13_e2;
    t_sb3        r_s13_sb;

    logic [64:0] s13_sum;

    assign d2_out  = r_d2[DIV_STAGES-1];
    assign s8_qx   = d2_out.zero ? 31'd0 : ((quo_x > ONE_Q30) ? ONE_Q30 : quo_x);
    assign s8_qy   = d2_out.zero ? 31'd0 : ((quo_y > ONE_Q30) ? ONE_Q30 : quo_y);
    assign s13_sum = {1'b0, r_s12_mx2} + {1'b0, r_s12_my2};

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // signed normal, zero for coincident centres
            r_s8_qx <= s8_qx;
            r_s8_qy <= s8_qy;
            r_s8_nx <= d2_out.neg_x ? -$signed(32'(s8_qx)) : $signed(32'(s8_qx));
            r_s8_ny <= d2_out.neg_y ? -$signed(32'(s8_qy)) : $signed(32'(s8_qy));
            r_s8_sb <= d2_out;
            // normal times radius
            r_s9_pxb <= 62'(r_s8_qx) * 62'(r_s8_sb.c.rb);
            r_s9_pyb <= 62'(r_s8_qy) * 62'(r_s8_sb.c.rb);
            r_s9_pxa <= 62'(r_s8_qx) * 62'(r_s8_sb.c.ra);
            r_s9_pya <= 62'(r_s8_qy) * 62'(r_s8_sb.c.ra);
            r_s9_nx  <= r_s8_nx;
            r_s9_ny  <= r_s8_ny;
            r_s9_sb  <= r_s8_sb;
            // rim points
            r_s10_sx   <= rim_pt(r_s9_sb.c.bx, r_s9_pxb, r_s9_sb.neg_x, 1'b1);
            r_s10_sy   <= rim_pt(r_s9_sb.c.by, r_s9_pyb, r_s9_sb.neg_y, 1'b1);
            r_s10_ex   <= rim_pt(r_s9_sb.c.ax, r_s9_pxa, r_s9_sb.neg_x, 1'b0);
            r_s10_ey   <= rim_pt(r_s9_sb.c.ay, r_s9_pya, r_s9_sb.neg_y, 1'b0);
            r_s10_nx   <= r_s9_nx;
            r_s10_ny   <= r_s9_ny;
            r_s10_coll <= r_s9_sb.coll;
            // end minus start
            r_s11_mx <= abs33(33'(r_s10_ex) - 33'(r_s10_sx));
            r_s11_my <= abs33(33'(r_s10_ey) - 33'(r_s10_sy));
            r_s11_sb <= '{coll: r_s10_coll, nx: r_s10_nx, ny: r_s10_ny,
                          sx: r_s10_sx, sy: r_s10_sy, ex: r_s10_ex, ey: r_s10_ey,
                          over: 1'b0};
            r_s12_mx2 <= 64'(r_s11_mx) * 64'(r_s11_mx);
            r_s12_my2 <= 64'(r_s11_my) * 64'(r_s11_my);
            r_s12_sb  <= r_s11_sb;
            // depth squared; a carry out means the depth saturates
            r_s13_e2 <= s13_sum[63:0];
            r_s13_sb <= '{coll: r_s12_sb.coll, nx: r_s12_sb.nx, ny: r_s12_sb.ny,
                          sx: r_s12_sb.sx, sy: r_s12_sb.sy, ex: r_s12_sb.ex,
                          ey: r_s12_sb.ey, over: s13_sum[64]};
        end
    end

    // ---------------- depth root ----------------
    logic [31:0] root;
    t_sb3        r_d3 [SQ_STAGES];
    t_sb3        d3_out;

    ccc_isqrt u_depth (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_rad  (r_s13_e2),
        .o_root (root)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d3[0] <= r_s13_sb;
            for (int k = 1; k < SQ_STAGES; k++) r_d3[k] <= r_d3[k-1];
        end
    end

    assign d3_out = r_d3[SQ_STAGES-1];

    // ---------------- output register ----------------
    t_sb3        r_o_sb;
    logic [31:0] r_o_depth;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_sb    <= d3_out;
            r_o_depth <= d3_out.over ? 32'hFFFF_FFFF : root;
        end
    end

    assign o_rsp.valid     = r_vld[LATENCY-1];
    assign o_rsp.colliding = r_o_sb.coll;
    assign o_rsp.normal_x  = r_o_sb.nx;
    assign o_rsp.normal_y  = r_o_sb.ny;
    assign o_rsp.start_x   = r_o_sb.sx;
    assign o_rsp.start_y   = r_o_sb.sy;
    assign o_rsp.end_x     = r_o_sb.ex;
    assign o_rsp.end_y     = r_o_sb.ey;
    assign o_rsp.depth     = r_o_depth;

    // ---------------- checks ----------------
    logic [31:0] nmag_x, nmag_y, nmag_max;

    assign nmag_x   = o_rsp.normal_x[31] ? 32'(-o_rsp.normal_x) : 32'(o_rsp.normal_x);
    assign nmag_y   = o_rsp.normal_y[31] ? 32'(-o_rsp.normal_y) : 32'(o_rsp.normal_y);
    assign nmag_max = (nmag_x > nmag_y) ? nmag_x : nmag_y;

    // pipe comes out of reset empty
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_rsp.valid)
        else $error("result valid straight after reset");

    // a held pipe keeps its valid bits
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld))
        else $error("valid bits moved during a stall");

    // a non-zero normal has unit length: its larger component is near or above 1/sqrt2
    a_unit_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.normal_x != 0 || o_rsp.normal_y != 0))
        |-> (nmag_max >= NRM_MIN && nmag_max <= 32'(ONE_Q30)))
        else $error("normal is not of unit length");

endmodule

// ===== rtl/ccc_isqrt.sv =====
// ----------------------------------------------------------------------------
// ccc_isqrt - pipelined integer square root
// floor(sqrt) of a 64-bit radicand, a fixed number of steps per stage.
// ----------------------------------------------------------------------------
module ccc_isqrt import ccc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);

    t_sq r_st [SQ_STAGES];

    // one group of root steps per stage
    for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stg
        t_sq stg_in;
        if (s == 0) begin : g_first
            assign stg_in = '{v: i_rad, res: 64'd0};
        end else begin : g_next
            assign stg_in = r_st[s-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) r_st[s] <= sq_stage(stg_in, s);
        end
    end

    assign o_root = r_st[SQ_STAGES-1].res[31:0];

endmodule

// ===== rtl/ccc_div.sv =====
// ----------------------------------------------------------------------------
// ccc_div - pipelined restoring divider
// 31-bit quotient of a 62-bit numerator by a 32-bit divisor.
// ----------------------------------------------------------------------------
module ccc_div import ccc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [61:0] i_num,
    input  logic [31:0] i_den,
    output logic [30:0] o_quo
);

    t_dv r_st [DIV_STAGES];

    // quotient bits from the top, a few per stage
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stg
        t_dv stg_in;
        if (s == 0) begin : g_first
            assign stg_in = '{rem: i_num, den: i_den, quo: 31'd0};
        end else begin : g_next
            assign stg_in = r_st[s-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) r_st[s] <= dv_stage(stg_in, s);
        end
    end

    assign o_quo = r_st[DIV_STAGES-1].quo;

endmodule
